// File: hdl/pat_pkg.sv
// Shared types and constants for the pending acknowledgement retry table.
package pat_pkg;

  localparam int SLOT_COUNT_DEF   = 10;
  localparam int ID_BITS_DEF      = 48;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Fixed port field widths
  localparam int CMD_W   = 8;
  localparam int ACK_W   = 8;
  localparam int ID_W    = 48;
  localparam int RETRY_W = 8;
  localparam int PAY_W   = 32;
  localparam int SLOT_W  = 4;

  localparam int IN_DATA_W  = 152;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 160;

  typedef enum logic [1:0] {
    KIND_STORE  = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CHECK  = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Control from the sequencer to the slot memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_valid;
  } mem_ctl_t;

  typedef struct packed {
    logic                 table_full;
    logic [PAY_W-1:0]     payload;
    logic [RETRY_W-1:0]   retries_left;
    logic [ID_W-1:0]      receiver;
    logic [ID_W-1:0]      sender;
    logic [ACK_W-1:0]     ack_mode;
    logic [CMD_W-1:0]     command;
    logic [SLOT_W-1:0]    slot;
    logic                 hit;
  } result_t;

endpackage

// File: hdl/pat_slot_mem.sv
// Slot storage: message memory with registered read and per-slot valid bits.
module pat_slot_mem #(
  parameter int SLOT_COUNT = pat_pkg::SLOT_COUNT_DEF,
  parameter int ENTRY_W    = 160,
  parameter int IDX_W      = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pat_pkg::mem_ctl_t    ctl,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [ENTRY_W-1:0]   wr_data,
  output logic [ENTRY_W-1:0]   rd_data,
  output logic                 rd_valid
);

  logic [ENTRY_W-1:0]    mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Occupancy flags; reset frees every slot at once
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[wr_addr] <= ctl.wr_valid;
      end
      if (ctl.rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

endmodule

// File: hdl/pat_scan_seq.sv
// Sequencer: latches a request and scans the slots one per cycle with one compare unit.
module pat_scan_seq #(
  parameter int SLOT_COUNT   = pat_pkg::SLOT_COUNT_DEF,
  parameter int ID_BITS      = pat_pkg::ID_BITS_DEF,
  parameter int PAYLOAD_BITS = pat_pkg::PAYLOAD_BITS_DEF,
  parameter int ENTRY_W      = 160,
  parameter int IDX_W        = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    req_kind,
  input  logic [pat_pkg::CMD_W-1:0]     req_command,
  input  logic [pat_pkg::ACK_W-1:0]     req_ack_mode,
  input  logic [pat_pkg::ID_W-1:0]      req_sender,
  input  logic [pat_pkg::ID_W-1:0]      req_receiver,
  input  logic [pat_pkg::RETRY_W-1:0]   req_retry,
  input  logic [pat_pkg::PAY_W-1:0]     req_payload,
  output pat_pkg::mem_ctl_t             mem_ctl,
  output logic [IDX_W-1:0]              mem_rd_addr,
  output logic [IDX_W-1:0]              mem_wr_addr,
  output logic [ENTRY_W-1:0]            mem_wr_data,
  input  logic [ENTRY_W-1:0]            mem_rd_data,
  input  logic                          mem_rd_valid,
  output logic                          res_valid,
  input  logic                          res_take,
  output pat_pkg::result_t              res
);

  localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
  localparam int PAY_LSB   = 0;
  localparam int RETRY_LSB = PAY_LSB + PAYLOAD_BITS;
  localparam int RCV_LSB   = RETRY_LSB + pat_pkg::RETRY_W;
  localparam int SND_LSB   = RCV_LSB + ID_BITS;
  localparam int ACK_LSB   = SND_LSB + ID_BITS;
  localparam int CMD_LSB   = ACK_LSB + pat_pkg::ACK_W;

  pat_pkg::state_t  state, state_next;
  pat_pkg::kind_t   kind, kind_next;
  logic [pat_pkg::CMD_W-1:0]   cmd, cmd_next;
  logic [pat_pkg::ACK_W-1:0]   ack, ack_next;
  logic [ID_BITS-1:0]          sender, sender_next;
  logic [ID_BITS-1:0]          receiver, receiver_next;
  logic [pat_pkg::RETRY_W-1:0] retry, retry_next;
  logic [PAYLOAD_BITS-1:0]     payload, payload_next;
  logic [CNT_W-1:0]            issue_cnt, issue_cnt_next;
  logic                        rd_live, rd_live_next;
  logic [IDX_W-1:0]            rd_idx, rd_idx_next;
  pat_pkg::result_t            res_next;

  logic [pat_pkg::CMD_W-1:0]   e_cmd;
  logic [pat_pkg::ACK_W-1:0]   e_ack;
  logic [ID_BITS-1:0]          e_snd;
  logic [ID_BITS-1:0]          e_rcv;
  logic [pat_pkg::RETRY_W-1:0] e_retry;
  logic [PAYLOAD_BITS-1:0]     e_pay;
  logic                        match;

  assign e_cmd   = mem_rd_data[CMD_LSB +: pat_pkg::CMD_W];
  assign e_ack   = mem_rd_data[ACK_LSB +: pat_pkg::ACK_W];
  assign e_snd   = mem_rd_data[SND_LSB +: ID_BITS];
  assign e_rcv   = mem_rd_data[RCV_LSB +: ID_BITS];
  assign e_retry = mem_rd_data[RETRY_LSB +: pat_pkg::RETRY_W];
  assign e_pay   = mem_rd_data[PAY_LSB +: PAYLOAD_BITS];

  always_comb begin
    case (kind)
      pat_pkg::KIND_STORE:  match = !mem_rd_valid;
      pat_pkg::KIND_REMOVE: match = mem_rd_valid && (e_cmd == cmd);
      pat_pkg::KIND_CHECK:  match = mem_rd_valid;
      default:              match = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pat_pkg::ST_IDLE;
      issue_cnt <= '0;
      rd_live   <= 1'b0;
    end else begin
      state     <= state_next;
      issue_cnt <= issue_cnt_next;
      rd_live   <= rd_live_next;
    end
  end

  always_ff @(posedge clk) begin
    kind     <= kind_next;
    cmd      <= cmd_next;
    ack      <= ack_next;
    sender   <= sender_next;
    receiver <= receiver_next;
    retry    <= retry_next;
    payload  <= payload_next;
    rd_idx   <= rd_idx_next;
    res      <= res_next;
  end

  always_comb begin
    state_next     = state;
    kind_next      = kind;
    cmd_next       = cmd;
    ack_next       = ack;
    sender_next    = sender;
    receiver_next  = receiver;
    retry_next     = retry;
    payload_next   = payload;
    issue_cnt_next = issue_cnt;
    rd_live_next   = 1'b0;
    rd_idx_next    = rd_idx;
    res_next       = res;
    mem_ctl        = '0;
    mem_rd_addr    = issue_cnt[IDX_W-1:0];
    mem_wr_addr    = rd_idx;
    mem_wr_data    = mem_rd_data;
    req_ready      = 1'b0;
    res_valid      = 1'b0;

    case (state)
      pat_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          kind_next      = pat_pkg::kind_t'(req_kind);
          cmd_next       = req_command;
          ack_next       = req_ack_mode;
          sender_next    = ID_BITS'(req_sender);
          receiver_next  = ID_BITS'(req_receiver);
          retry_next     = req_retry;
          payload_next   = PAYLOAD_BITS'(req_payload);
          issue_cnt_next = '0;
          res_next       = '0;
          // Reserved kind, or store/remove of an empty command: nothing to do
          if (req_kind == pat_pkg::KIND_RSVD ||
              (req_kind != pat_pkg::KIND_CHECK && req_command == '0)) begin
            state_next = pat_pkg::ST_DONE;
          end else begin
            state_next = pat_pkg::ST_SCAN;
          end
        end
      end

      pat_pkg::ST_SCAN: begin
        // Issue the next slot read while the previous one is tested
        if (issue_cnt < CNT_W'(SLOT_COUNT)) begin
          mem_ctl.rd_en  = 1'b1;
          issue_cnt_next = issue_cnt + 1'b1;
          rd_live_next   = 1'b1;
          rd_idx_next    = issue_cnt[IDX_W-1:0];
        end
        if (rd_live) begin
          if (match) begin
            mem_ctl.rd_en = 1'b0;
            rd_live_next  = 1'b0;
            rd_idx_next   = rd_idx;
            mem_ctl.wr_en = 1'b1;
            res_next.hit  = 1'b1;
            res_next.slot = pat_pkg::SLOT_W'(rd_idx);
            state_next    = pat_pkg::ST_DONE;
            case (kind)
              pat_pkg::KIND_STORE: begin
                mem_ctl.wr_valid = 1'b1;
                mem_wr_data      = {cmd, ack, sender, receiver, retry, payload};
              end
              pat_pkg::KIND_CHECK: begin
                res_next.command      = e_cmd;
                res_next.ack_mode     = e_ack;
                res_next.sender       = pat_pkg::ID_W'(e_snd);
                res_next.receiver     = pat_pkg::ID_W'(e_rcv);
                res_next.retries_left = e_retry;
                res_next.payload      = pat_pkg::PAY_W'(e_pay);
                // Free the slot on its last retry, otherwise count down
                mem_ctl.wr_valid = (e_retry > pat_pkg::RETRY_W'(1));
                mem_wr_data      = {e_cmd, e_ack, e_snd, e_rcv,
                                    e_retry - 1'b1, e_pay};
              end
              default: begin
                mem_ctl.wr_valid = 1'b0;
              end
            endcase
          end else if (rd_idx == IDX_W'(SLOT_COUNT - 1)) begin
            mem_ctl.rd_en       = 1'b0;
            rd_live_next        = 1'b0;
            res_next.table_full = (kind == pat_pkg::KIND_STORE);
            state_next          = pat_pkg::ST_DONE;
          end
        end
      end

      pat_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = pat_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = pat_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/pending_ack_retry_table.sv
// Top level of the pending acknowledgement retry table.
//
// Usage: each request on the s_ group is a store (tuser = 0), a remove on
// acknowledgement (tuser = 1) or a retransmission check (tuser = 2); every
// request gives exactly one response on the m_ group.
// A store writes the message into the lowest free slot or reports
// table_full; a remove frees the lowest slot with a matching command; a
// check returns the lowest occupied slot with its retry count, then counts
// it down and frees the slot once the count runs out.
// Scan: a request walks the slots one per cycle through a single compare
// unit fed from the slot memory's registered read port.
// s_tready is high only while the sequencer is idle, one request at a time,
// so a new request is taken only once the last one has left the sequencer.
// Stall: the response sits in the output register; the next request is taken
// meanwhile, and its result holds in the sequencer until the register frees.
// Reset: rst (synchronous) clears the occupancy bits, so all slots are free,
// and drops any request or response in flight.
module pending_ack_retry_table #(
  parameter int SLOT_COUNT   = pat_pkg::SLOT_COUNT_DEF,
  parameter int ID_BITS      = pat_pkg::ID_BITS_DEF,
  parameter int PAYLOAD_BITS = pat_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // command[7:0], ack_mode[15:8], sender_id[63:16], receiver_id[111:64],
  // retry_count[119:112], payload_ref[151:120]
  input  logic [pat_pkg::IN_DATA_W-1:0]    s_tdata,
  // kind[1:0]
  input  logic [pat_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // hit[0], slot[4:1], out_command[12:5], out_ack_mode[20:13],
  // out_sender[68:21], out_receiver[116:69], retries_left[124:117],
  // out_payload[156:125], table_full[157], zero fill[159:158]
  output logic [pat_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ENTRY_W = pat_pkg::CMD_W + pat_pkg::ACK_W + 2 * ID_BITS +
                           pat_pkg::RETRY_W + PAYLOAD_BITS;

  pat_pkg::mem_ctl_t    mem_ctl;
  logic [IDX_W-1:0]     mem_rd_addr;
  logic [IDX_W-1:0]     mem_wr_addr;
  logic [ENTRY_W-1:0]   mem_wr_data;
  logic [ENTRY_W-1:0]   mem_rd_data;
  logic                 mem_rd_valid;
  logic                 res_valid;
  logic                 res_take;
  pat_pkg::result_t     res;
  pat_pkg::result_t     out_res;

  pat_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .ENTRY_W    (ENTRY_W),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mem_ctl),
    .rd_addr  (mem_rd_addr),
    .wr_addr  (mem_wr_addr),
    .wr_data  (mem_wr_data),
    .rd_data  (mem_rd_data),
    .rd_valid (mem_rd_valid)
  );

  pat_scan_seq #(
    .SLOT_COUNT   (SLOT_COUNT),
    .ID_BITS      (ID_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .ENTRY_W      (ENTRY_W),
    .IDX_W        (IDX_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (s_tvalid),
    .req_ready    (s_tready),
    .req_kind     (s_tuser),
    .req_command  (s_tdata[7:0]),
    .req_ack_mode (s_tdata[15:8]),
    .req_sender   (s_tdata[63:16]),
    .req_receiver (s_tdata[111:64]),
    .req_retry    (s_tdata[119:112]),
    .req_payload  (s_tdata[151:120]),
    .mem_ctl      (mem_ctl),
    .mem_rd_addr  (mem_rd_addr),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_data  (mem_rd_data),
    .mem_rd_valid (mem_rd_valid),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  // Load the response register whenever it is empty or being drained
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.table_full, out_res.payload, out_res.retries_left,
                    out_res.receiver, out_res.sender, out_res.ack_mode,
                    out_res.command, out_res.slot, out_res.hit};

endmodule

// File: verif/pat_tb_pkg.sv
// Message type and response scoreboard for the retry table testbench.
package pat_tb_pkg;
  import pat_pkg::*;

  // One pending message, laid out as it travels on s_tdata (command lowest).
  typedef struct packed {
    logic [PAY_W-1:0]   payload;
    logic [RETRY_W-1:0] retry;
    logic [ID_W-1:0]    receiver;
    logic [ID_W-1:0]    sender;
    logic [ACK_W-1:0]   ack_mode;
    logic [CMD_W-1:0]   command;
  } message_t;

  class ack_table_scoreboard;
    localparam int SLOTS = SLOT_COUNT_DEF;

    message_t slots[SLOTS];
    result_t  expected_responses[$];
    int errors;
    int responses;
    int store_hits;
    int drops;
    int remove_hits;
    int check_hits;
    int retired;

    function new();
      foreach (slots[i]) slots[i] = '0;
      errors      = 0;
      responses   = 0;
      store_hits  = 0;
      drops       = 0;
      remove_hits = 0;
      check_hits  = 0;
      retired     = 0;
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    // Apply one accepted request to the table copy and queue its response.
    function void note_request(kind_t kind, message_t msg);
      result_t res;
      int idx;
      res = '0;
      idx = -1;
      case (kind)
        KIND_STORE: begin
          if (msg.command != '0) begin
            for (int i = 0; i < SLOTS && idx < 0; i++)
              if (slots[i].command == '0) idx = i;
            if (idx >= 0) begin
              slots[idx] = msg;
              res.hit    = 1'b1;
              res.slot   = SLOT_W'(idx);
              store_hits++;
            end else begin
              res.table_full = 1'b1;
              drops++;
            end
          end
        end
        KIND_REMOVE: begin
          if (msg.command != '0) begin
            for (int i = 0; i < SLOTS && idx < 0; i++)
              if (slots[i].command == msg.command) idx = i;
            if (idx >= 0) begin
              slots[idx] = '0;
              res.hit    = 1'b1;
              res.slot   = SLOT_W'(idx);
              remove_hits++;
            end
          end
        end
        KIND_CHECK: begin
          for (int i = 0; i < SLOTS && idx < 0; i++)
            if (slots[i].command != '0) idx = i;
          if (idx >= 0) begin
            res.hit          = 1'b1;
            res.slot         = SLOT_W'(idx);
            res.command      = slots[idx].command;
            res.ack_mode     = slots[idx].ack_mode;
            res.sender       = slots[idx].sender;
            res.receiver     = slots[idx].receiver;
            res.retries_left = slots[idx].retry;
            res.payload      = slots[idx].payload;
            check_hits++;
            // a count of zero or one runs out here; no wrap
            if (slots[idx].retry <= 8'd1) begin
              slots[idx] = '0;
              retired++;
            end else begin
              slots[idx].retry = slots[idx].retry - 8'd1;
            end
          end
        end
        default: ;
      endcase
      expected_responses.push_back(res);
    endfunction

    function void report_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(logic [OUT_DATA_W-1:0] word);
      result_t want;
      result_t got;
      responses++;
      if (expected_responses.size() == 0) begin
        $display("%0t: response with nothing outstanding: expected none, actual %h",
                 $time, word);
        errors++;
        return;
      end
      want = expected_responses.pop_front();
      got  = word[$bits(result_t)-1:0];
      report_field("hit", want.hit, got.hit);
      report_field("slot", want.slot, got.slot);
      report_field("out_command", want.command, got.command);
      report_field("out_ack_mode", want.ack_mode, got.ack_mode);
      report_field("out_sender", want.sender, got.sender);
      report_field("out_receiver", want.receiver, got.receiver);
      report_field("retries_left", want.retries_left, got.retries_left);
      report_field("out_payload", want.payload, got.payload);
      report_field("table_full", want.table_full, got.table_full);
      report_field("zero fill", '0, word[OUT_DATA_W-1:$bits(result_t)]);
    endfunction

    function void report_leftovers();
      if (expected_responses.size() != 0) begin
        $display("%0t: %0d responses never arrived", $time, expected_responses.size());
        errors += expected_responses.size();
      end
    endfunction
  endclass

endpackage

// File: verif/testbench.sv
// Top-level testbench for the pending acknowledgement retry table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pat_pkg::*;
  import pat_tb_pkg::*;

  // Counted requests in the random part; reserved kinds and stores with a
  // zero command are left out of the count.
  localparam int REQUESTS     = 1850;
  // A full scan, sender gaps and receiver stalls all stay far below this limit.
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [IN_USER_W-1:0]  s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_tdata;

  ack_table_scoreboard board = new();

  int idle_cycles      = 0;
  int ready_phase_left = 0;
  int stall_pct        = 0;
  int burst_left       = 0;
  bit gaps_on          = 1'b1;
  int phases           = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pending_ack_retry_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Receiver: check each response taken at this edge, then pick the next
  // ready level. Back-pressure runs in phases of random length, from none
  // at all to heavy stalling, so responses back up behind the output
  // register in some phases and flow freely in others.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_response(m_tdata);
    end
    if (ready_phase_left == 0) begin
      ready_phase_left = $urandom_range(50, 400);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    ready_phase_left--;
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: end the run when no request and no response has moved for
  // the whole IDLE_LIMIT window.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request and hold it until the block takes it; note it in
  // the scoreboard at the accepting edge. Valid stays high on return so a
  // back-to-back request follows without a bubble.
  task automatic send_request(input kind_t kind, input message_t msg);
    s_tuser  <= kind;
    s_tdata  <= msg;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(kind, msg);
  endtask

  // Drop valid and idle the sender for a number of cycles.
  task automatic hold_sender(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every queued response has come back.
  task automatic drain_responses();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Send in bursts of random length with random gaps between them; with
  // gaps off, requests go back to back.
  task automatic paced_request(input kind_t kind, input message_t msg);
    if (gaps_on) begin
      if (burst_left == 0) begin
        hold_sender($urandom_range(1, 20));
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
    end
    send_request(kind, msg);
  endtask

  // Random message content. A narrow command pool makes removes find their
  // message and lets duplicate commands sit in the table together; retry
  // counts are mostly small so that checks free slots often.
  function automatic message_t random_message(input bit narrow);
    message_t m;
    m.command  = narrow ? CMD_W'($urandom_range(1, 12)) : CMD_W'($urandom_range(0, 255));
    m.ack_mode = ACK_W'($urandom);
    m.sender   = ID_W'({$urandom, $urandom});
    m.receiver = ID_W'({$urandom, $urandom});
    m.retry    = ($urandom_range(0, 9) < 7) ? RETRY_W'($urandom_range(0, 3))
                                            : RETRY_W'($urandom);
    m.payload  = PAY_W'($urandom);
    return m;
  endfunction

  initial begin
    message_t msg;
    kind_t    kind;
    int       counted;
    int       phase_left;
    int       store_pct;
    int       remove_pct;
    int       pick;
    bit       narrow;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty-table and zero-command corners first.
    gaps_on = 1'b0;
    send_request(KIND_CHECK, '0);
    send_request(KIND_REMOVE, '0);
    msg = '1;
    msg.command = '0;
    send_request(KIND_STORE, msg);   // ignored, table untouched
    send_request(KIND_RSVD, '1);     // reserved kind, all-zero response

    // Fill three slots: all-ones message, retry of zero, retry of one.
    send_request(KIND_STORE, '1);
    msg = '0;
    msg.command = 8'h01;
    send_request(KIND_STORE, msg);
    msg = random_message(1'b0);
    msg.command = 8'h80;
    msg.retry   = 8'd1;
    send_request(KIND_STORE, msg);

    gaps_on = 1'b1;
    send_request(KIND_CHECK, '0);    // slot 0, count 255 before decrement
    msg = '0;
    msg.command = 8'hFF;
    paced_request(KIND_REMOVE, msg); // acknowledge frees slot 0
    paced_request(KIND_CHECK, '0);   // retry zero: freed, no wrap
    paced_request(KIND_CHECK, '0);   // retry one: freed
    msg.command = 8'h42;
    paced_request(KIND_REMOVE, msg); // no match

    // Fill every slot, then overflow once.
    for (int i = 0; i < 11; i++) begin
      msg = random_message(1'b0);
      msg.command = CMD_W'(i + 2);
      msg.retry   = 8'd2;
      paced_request(KIND_STORE, msg);
    end

    // Random part in phases with their own request mix and pacing. Hold the
    // sender at each phase boundary until every response is back.
    counted    = 0;
    phase_left = 0;
    store_pct  = 0;
    remove_pct = 0;
    narrow     = 1'b1;
    while (counted < REQUESTS) begin
      if (phase_left == 0) begin
        drain_responses();
        phase_left = $urandom_range(100, 250);
        store_pct  = $urandom_range(20, 60);
        remove_pct = $urandom_range(10, 30);
        gaps_on    = ($urandom_range(0, 3) != 0);
        narrow     = ($urandom_range(0, 4) != 0);
        phases++;
      end
      msg  = random_message(narrow);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        kind = KIND_RSVD;
      end else if (pick < 3 + store_pct) begin
        kind = KIND_STORE;
      end else if (pick < 3 + store_pct + remove_pct) begin
        kind = KIND_REMOVE;
      end else begin
        kind = KIND_CHECK;
      end
      paced_request(kind, msg);
      if (kind != KIND_RSVD && !(kind == KIND_STORE && msg.command == '0)) begin
        counted++;
        phase_left--;
      end
    end

    // Let the last responses out, then give the block time to go quiet.
    drain_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.report_leftovers();

    $display("Covered %0d responses over %0d random phases: %0d stores placed, %0d dropped full,",
             board.responses, phases, board.store_hits, board.drops);
    $display("  %0d acknowledged removes, %0d retry checks hit, %0d slots run out of retries",
             board.remove_hits, board.check_hits, board.retired);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/pat_pkg.sv
hdl/pat_slot_mem.sv
hdl/pat_scan_seq.sv
hdl/pending_ack_retry_table.sv
verif/pat_tb_pkg.sv
verif/testbench.sv
